>>> hdl/ewdc_pkg.sv
package ewdc_pkg;

    localparam int SUM_W   = 24;
    localparam int CNT_W   = 17;
    localparam int PIX_W   = 8;
    localparam int ORG_W   = 11;
    localparam int CTR_W   = 12;
    localparam int DIFF_W  = 13;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 11;

    localparam int STEP_W  = $clog2(SUM_W);

    localparam int JOB_DEPTH = 4;
    localparam int JOB_AW    = $clog2(JOB_DEPTH);
    localparam int JOB_LW    = $clog2(JOB_DEPTH + 1);

    // luma weights, Q14
    localparam int PROD_B_W = 19;
    localparam int PROD_G_W = 22;
    localparam int PROD_R_W = 21;
    localparam int GRAY_SUM_W = 22;
    localparam logic [PROD_B_W-1:0] LUMA_B = PROD_B_W'(1868);
    localparam logic [PROD_G_W-1:0] LUMA_G = PROD_G_W'(9617);
    localparam logic [PROD_R_W-1:0] LUMA_R = PROD_R_W'(4899);
    localparam logic [GRAY_SUM_W-1:0] LUMA_ROUND = GRAY_SUM_W'(8192);
    localparam int GRAY_SHIFT = 14;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [PIX_W-1:0] OFFSET_MAX = '1;

    localparam logic [PIX_W-1:0] THRESHOLD_RESET = PIX_W'(30);

    localparam logic [CFG_IW-1:0] REG_GRAY_THRESHOLD = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] REG_LEFT_ORIGIN_X  = CFG_IW'(1);
    localparam logic [CFG_IW-1:0] REG_LEFT_ORIGIN_Y  = CFG_IW'(2);
    localparam logic [CFG_IW-1:0] REG_RIGHT_ORIGIN_X = CFG_IW'(3);
    localparam logic [CFG_IW-1:0] REG_RIGHT_ORIGIN_Y = CFG_IW'(4);

    localparam logic EYE_LEFT  = 1'b0;
    localparam logic EYE_RIGHT = 1'b1;

    // one finished window, handed from the accumulators to the divider
    typedef struct packed {
        logic             eye;
        logic [SUM_W-1:0] sum_col;
        logic [SUM_W-1:0] sum_row;
        logic [CNT_W-1:0] count;
    } job_t;

endpackage

>>> hdl/ewdc_front.sv
module ewdc_front
    import ewdc_pkg::*;
#(
    parameter int WINDOW_SIDE = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              eye_select,
    input  logic [PIX_W-1:0]  pixel_col,
    input  logic [PIX_W-1:0]  pixel_row,
    input  logic [PIX_W-1:0]  blue,
    input  logic [PIX_W-1:0]  green,
    input  logic [PIX_W-1:0]  red,
    input  logic              window_end,
    input  logic [PIX_W-1:0]  gray_threshold,
    input  logic [JOB_LW-1:0] job_level,
    output logic              job_push,
    output job_t              job
);

    // stage 1: luma products
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_eye_reg;
    logic [PIX_W-1:0]    s1_col_reg;
    logic [PIX_W-1:0]    s1_row_reg;
    logic                s1_last_reg;
    logic                s1_inwin_reg;
    logic [PROD_B_W-1:0] s1_pb_reg;
    logic [PROD_G_W-1:0] s1_pg_reg;
    logic [PROD_R_W-1:0] s1_pr_reg;

    // stage 2: threshold decision
    logic                s2_valid_reg, s2_valid_next;
    logic                s2_eye_reg;
    logic [PIX_W-1:0]    s2_col_reg;
    logic [PIX_W-1:0]    s2_row_reg;
    logic                s2_last_reg;
    logic                s2_kept_reg;

    logic [SUM_W-1:0] l_col_reg, l_col_next;
    logic [SUM_W-1:0] l_row_reg, l_row_next;
    logic [CNT_W-1:0] l_cnt_reg, l_cnt_next;
    logic [SUM_W-1:0] r_col_reg, r_col_next;
    logic [SUM_W-1:0] r_row_reg, r_row_next;
    logic [CNT_W-1:0] r_cnt_reg, r_cnt_next;

    logic                  accept;
    logic                  in_window;
    logic [GRAY_SUM_W-1:0] gray_sum;
    logic [PIX_W-1:0]      gray;
    logic                  s2_kept;
    logic [JOB_LW:0]       pending;

    logic [SUM_W-1:0] cur_col, cur_row, new_col, new_row;
    logic [CNT_W-1:0] cur_cnt, new_cnt;
    logic [SUM_W:0]   add_col, add_row;
    logic [CNT_W:0]   add_cnt;

    // count window ends still in the pipe so the job queue can never overflow
    assign pending = (JOB_LW+1)'(job_level)
                   + (JOB_LW+1)'(s1_valid_reg & s1_last_reg)
                   + (JOB_LW+1)'(s2_valid_reg & s2_last_reg);
    assign full   = pending >= (JOB_LW+1)'(JOB_DEPTH);
    assign accept = push && !full;

    assign in_window = (int'(pixel_col) < WINDOW_SIDE) && (int'(pixel_row) < WINDOW_SIDE);

    assign gray_sum = GRAY_SUM_W'(s1_pb_reg) + GRAY_SUM_W'(s1_pg_reg)
                    + GRAY_SUM_W'(s1_pr_reg) + LUMA_ROUND;
    assign gray     = gray_sum[GRAY_SHIFT +: PIX_W];
    assign s2_kept  = s1_inwin_reg && (gray > gray_threshold);

    assign s1_valid_next = accept;
    assign s2_valid_next = s1_valid_reg;

    always_comb
    begin
        cur_col = (s2_eye_reg == EYE_RIGHT) ? r_col_reg : l_col_reg;
        cur_row = (s2_eye_reg == EYE_RIGHT) ? r_row_reg : l_row_reg;
        cur_cnt = (s2_eye_reg == EYE_RIGHT) ? r_cnt_reg : l_cnt_reg;

        add_col = {1'b0, cur_col} + (SUM_W+1)'(s2_col_reg);
        add_row = {1'b0, cur_row} + (SUM_W+1)'(s2_row_reg);
        add_cnt = {1'b0, cur_cnt} + (CNT_W+1)'(1);

        new_col = cur_col;
        new_row = cur_row;
        new_cnt = cur_cnt;
        if (s2_kept_reg)
        begin
            new_col = add_col[SUM_W] ? SUM_MAX : add_col[SUM_W-1:0];
            new_row = add_row[SUM_W] ? SUM_MAX : add_row[SUM_W-1:0];
            new_cnt = add_cnt[CNT_W] ? CNT_MAX : add_cnt[CNT_W-1:0];
        end

        job_push     = s2_valid_reg && s2_last_reg;
        job.eye      = s2_eye_reg;
        job.sum_col  = new_col;
        job.sum_row  = new_row;
        job.count    = new_cnt;

        l_col_next = l_col_reg;
        l_row_next = l_row_reg;
        l_cnt_next = l_cnt_reg;
        r_col_next = r_col_reg;
        r_row_next = r_row_reg;
        r_cnt_next = r_cnt_reg;
        if (s2_valid_reg)
        begin
            if (s2_eye_reg == EYE_RIGHT)
            begin
                r_col_next = s2_last_reg ? '0 : new_col;
                r_row_next = s2_last_reg ? '0 : new_row;
                r_cnt_next = s2_last_reg ? '0 : new_cnt;
            end
            else
            begin
                l_col_next = s2_last_reg ? '0 : new_col;
                l_row_next = s2_last_reg ? '0 : new_row;
                l_cnt_next = s2_last_reg ? '0 : new_cnt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            l_col_reg    <= '0;
            l_row_reg    <= '0;
            l_cnt_reg    <= '0;
            r_col_reg    <= '0;
            r_row_reg    <= '0;
            r_cnt_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            l_col_reg    <= l_col_next;
            l_row_reg    <= l_row_next;
            l_cnt_reg    <= l_cnt_next;
            r_col_reg    <= r_col_next;
            r_row_reg    <= r_row_next;
            r_cnt_reg    <= r_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_eye_reg   <= eye_select;
            s1_col_reg   <= pixel_col;
            s1_row_reg   <= pixel_row;
            s1_last_reg  <= window_end;
            s1_inwin_reg <= in_window;
            s1_pb_reg    <= LUMA_B * PROD_B_W'(blue);
            s1_pg_reg    <= LUMA_G * PROD_G_W'(green);
            s1_pr_reg    <= LUMA_R * PROD_R_W'(red);
        end
        if (s1_valid_reg)
        begin
            s2_eye_reg  <= s1_eye_reg;
            s2_col_reg  <= s1_col_reg;
            s2_row_reg  <= s1_row_reg;
            s2_last_reg <= s1_last_reg;
            s2_kept_reg <= s2_kept;
        end
    end

endmodule

>>> hdl/ewdc_job_fifo.sv
module ewdc_job_fifo
    import ewdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  job_t              din,
    input  logic              pop,
    output job_t              dout,
    output logic [JOB_LW-1:0] level
);

    job_t              slot_reg [JOB_DEPTH];
    logic [JOB_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [JOB_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [JOB_LW-1:0] level_reg, level_next;

    assign dout  = slot_reg[rd_ptr_reg];
    assign level = level_reg;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + JOB_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + JOB_AW'(1) : rd_ptr_reg;
        level_next  = level_reg + JOB_LW'(push) - JOB_LW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

>>> hdl/ewdc_back.sv
module ewdc_back
    import ewdc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [JOB_LW-1:0]        job_level,
    input  job_t                     job,
    output logic                     job_pop,
    input  logic [ORG_W-1:0]         left_origin_x,
    input  logic [ORG_W-1:0]         left_origin_y,
    input  logic [ORG_W-1:0]         right_origin_x,
    input  logic [ORG_W-1:0]         right_origin_y,
    input  logic                     pop,
    output logic                     result_valid,
    output logic                     result_load,
    output logic [CTR_W-1:0]         left_center_x,
    output logic [CTR_W-1:0]         left_center_y,
    output logic [CTR_W-1:0]         right_center_x,
    output logic [CTR_W-1:0]         right_center_y,
    output logic signed [DIFF_W-1:0] diff_x,
    output logic signed [DIFF_W-1:0] diff_y
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0] rem;
        logic [SUM_W-1:0] quot;
    } div_t;

    state_t              state_reg, state_next;
    logic                eye_reg, eye_next;
    logic [CNT_W-1:0]    den_reg, den_next;
    div_t                dx_reg, dx_next;
    div_t                dy_reg, dy_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [PIX_W-1:0]    loff_x_reg, loff_x_next;
    logic [PIX_W-1:0]    loff_y_reg, loff_y_next;
    logic                out_valid_reg, out_valid_next;
    logic [CTR_W-1:0]    lcx_reg, lcx_next;
    logic [CTR_W-1:0]    lcy_reg, lcy_next;
    logic [CTR_W-1:0]    rcx_reg, rcx_next;
    logic [CTR_W-1:0]    rcy_reg, rcy_next;
    logic [DIFF_W-1:0]   dfx_reg, dfx_next;
    logic [DIFF_W-1:0]   dfy_reg, dfy_next;

    logic [PIX_W-1:0]    off_x, off_y;
    logic [CTR_W-1:0]    lcx, lcy, rcx, rcy;
    logic                out_free;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic div_t div_step(input div_t cur, input logic [CNT_W-1:0] den);
        logic [CNT_W:0] shifted;
        logic           fits;
        div_t           nxt;
        shifted  = {cur.rem, cur.quot[SUM_W-1]};
        fits     = shifted >= {1'b0, den};
        nxt.rem  = fits ? CNT_W'(shifted - {1'b0, den}) : shifted[CNT_W-1:0];
        nxt.quot = {cur.quot[SUM_W-2:0], fits};
        return nxt;
    endfunction

    function automatic logic [PIX_W-1:0] clamp_offset(input logic [SUM_W-1:0] quot,
                                                      input logic [CNT_W-1:0] den);
        logic [PIX_W-1:0] res;
        if (den == '0)
        begin
            res = '0;
        end
        else if (|quot[SUM_W-1:PIX_W])
        begin
            res = OFFSET_MAX;
        end
        else
        begin
            res = quot[PIX_W-1:0];
        end
        return res;
    endfunction

    assign off_x    = clamp_offset(dx_reg.quot, den_reg);
    assign off_y    = clamp_offset(dy_reg.quot, den_reg);
    assign lcx      = CTR_W'(left_origin_x) + CTR_W'(loff_x_reg);
    assign lcy      = CTR_W'(left_origin_y) + CTR_W'(loff_y_reg);
    assign rcx      = CTR_W'(right_origin_x) + CTR_W'(off_x);
    assign rcy      = CTR_W'(right_origin_y) + CTR_W'(off_y);
    assign out_free = !out_valid_reg || pop;

    always_comb
    begin
        state_next     = state_reg;
        eye_next       = eye_reg;
        den_next       = den_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        step_next      = step_reg;
        loff_x_next    = loff_x_reg;
        loff_y_next    = loff_y_reg;
        out_valid_next = out_valid_reg && !pop;
        lcx_next       = lcx_reg;
        lcy_next       = lcy_reg;
        rcx_next       = rcx_reg;
        rcy_next       = rcy_reg;
        dfx_next       = dfx_reg;
        dfy_next       = dfy_reg;
        job_pop        = 1'b0;
        result_load    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_level != '0)
                begin
                    job_pop      = 1'b1;
                    eye_next     = job.eye;
                    den_next     = job.count;
                    dx_next.rem  = '0;
                    dx_next.quot = job.sum_col;
                    dy_next.rem  = '0;
                    dy_next.quot = job.sum_row;
                    step_next    = '0;
                    state_next   = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                dx_next   = div_step(dx_reg, den_reg);
                dy_next   = div_step(dy_reg, den_reg);
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (eye_reg == EYE_LEFT)
                begin
                    loff_x_next = off_x;
                    loff_y_next = off_y;
                    state_next  = ST_IDLE;
                end
                else if (out_free)
                begin
                    result_load    = 1'b1;
                    out_valid_next = 1'b1;
                    lcx_next       = lcx;
                    lcy_next       = lcy;
                    rcx_next       = rcx;
                    rcy_next       = rcy;
                    dfx_next       = DIFF_W'(rcx) - DIFF_W'(lcx);
                    dfy_next       = DIFF_W'(rcy) - DIFF_W'(lcy);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            eye_reg       <= EYE_LEFT;
            den_reg       <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            step_reg      <= '0;
            loff_x_reg    <= '0;
            loff_y_reg    <= '0;
            out_valid_reg <= 1'b0;
            lcx_reg       <= '0;
            lcy_reg       <= '0;
            rcx_reg       <= '0;
            rcy_reg       <= '0;
            dfx_reg       <= '0;
            dfy_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            eye_reg       <= eye_next;
            den_reg       <= den_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            step_reg      <= step_next;
            loff_x_reg    <= loff_x_next;
            loff_y_reg    <= loff_y_next;
            out_valid_reg <= out_valid_next;
            lcx_reg       <= lcx_next;
            lcy_reg       <= lcy_next;
            rcx_reg       <= rcx_next;
            rcy_reg       <= rcy_next;
            dfx_reg       <= dfx_next;
            dfy_reg       <= dfy_next;
        end
    end

    assign result_valid   = out_valid_reg;
    assign left_center_x  = lcx_reg;
    assign left_center_y  = lcy_reg;
    assign right_center_x = rcx_reg;
    assign right_center_y = rcy_reg;
    assign diff_x         = $signed(dfx_reg);
    assign diff_y         = $signed(dfy_reg);

endmodule

>>> hdl/eye_window_dark_centroid.sv
// Channel  | Handshake        | Transaction
// ---------+------------------+--------------------------------------------------
// pixel in | push / full      | eye_select, pixel_col, pixel_row, blue, green,
//          |                  | red, window_end
// result   | empty / pop      | left/right_center_x/y, diff_x, diff_y
// config   | cfg_write        | cfg_index, cfg_data (no wait, no read-back)
//
// One pixel per cycle while full is low; gray, threshold and accumulation run
// in a 3-stage pipe. Each window end becomes a job for the divider, which does
// restoring division (column and row in parallel), one job at a time.
// Up to 4 finished windows queue between the pipe and the divider; full rises
// when that queue plus the window ends in flight reach 4.
// A result waits in its output register; a second one stalls the divider until pop.
// Reset: threshold 30, origins, sums and held left offsets cleared.
module eye_window_dark_centroid
    import ewdc_pkg::*;
#(
    parameter int WINDOW_SIDE = 256
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic                     eye_select,
    input  logic [PIX_W-1:0]         pixel_col,
    input  logic [PIX_W-1:0]         pixel_row,
    input  logic [PIX_W-1:0]         blue,
    input  logic [PIX_W-1:0]         green,
    input  logic [PIX_W-1:0]         red,
    input  logic                     window_end,
    output logic                     empty,
    input  logic                     pop,
    output logic [CTR_W-1:0]         left_center_x,
    output logic [CTR_W-1:0]         left_center_y,
    output logic [CTR_W-1:0]         right_center_x,
    output logic [CTR_W-1:0]         right_center_y,
    output logic signed [DIFF_W-1:0] diff_x,
    output logic signed [DIFF_W-1:0] diff_y,
    input  logic                     cfg_write,
    input  logic [CFG_IW-1:0]        cfg_index,
    input  logic [CFG_DW-1:0]        cfg_data
);

    logic [PIX_W-1:0] thr_reg, thr_next;
    logic [ORG_W-1:0] lox_reg, lox_next;
    logic [ORG_W-1:0] loy_reg, loy_next;
    logic [ORG_W-1:0] rox_reg, rox_next;
    logic [ORG_W-1:0] roy_reg, roy_next;

    logic              job_push;
    logic              job_pop;
    job_t              job_in;
    job_t              job_out;
    logic [JOB_LW-1:0] job_level;
    logic              result_valid;
    logic              result_load;

    always_comb
    begin
        thr_next = thr_reg;
        lox_next = lox_reg;
        loy_next = loy_reg;
        rox_next = rox_reg;
        roy_next = roy_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GRAY_THRESHOLD: thr_next = cfg_data[PIX_W-1:0];
                REG_LEFT_ORIGIN_X:  lox_next = cfg_data[ORG_W-1:0];
                REG_LEFT_ORIGIN_Y:  loy_next = cfg_data[ORG_W-1:0];
                REG_RIGHT_ORIGIN_X: rox_next = cfg_data[ORG_W-1:0];
                REG_RIGHT_ORIGIN_Y: roy_next = cfg_data[ORG_W-1:0];
                default:            thr_next = thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESHOLD_RESET;
            lox_reg <= '0;
            loy_reg <= '0;
            rox_reg <= '0;
            roy_reg <= '0;
        end
        else
        begin
            thr_reg <= thr_next;
            lox_reg <= lox_next;
            loy_reg <= loy_next;
            rox_reg <= rox_next;
            roy_reg <= roy_next;
        end
    end

    ewdc_front #(
        .WINDOW_SIDE (WINDOW_SIDE)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .eye_select     (eye_select),
        .pixel_col      (pixel_col),
        .pixel_row      (pixel_row),
        .blue           (blue),
        .green          (green),
        .red            (red),
        .window_end     (window_end),
        .gray_threshold (thr_reg),
        .job_level      (job_level),
        .job_push       (job_push),
        .job            (job_in)
    );

    ewdc_job_fifo u_job_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (job_in),
        .pop   (job_pop),
        .dout  (job_out),
        .level (job_level)
    );

    ewdc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_level      (job_level),
        .job            (job_out),
        .job_pop        (job_pop),
        .left_origin_x  (lox_reg),
        .left_origin_y  (loy_reg),
        .right_origin_x (rox_reg),
        .right_origin_y (roy_reg),
        .pop            (pop),
        .result_valid   (result_valid),
        .result_load    (result_load),
        .left_center_x  (left_center_x),
        .left_center_y  (left_center_y),
        .right_center_x (right_center_x),
        .right_center_y (right_center_y),
        .diff_x         (diff_x),
        .diff_y         (diff_y)
    );

    assign empty = !result_valid;

    // the in-flight accounting in the front must keep the job queue from overflowing
    assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> job_level != JOB_LW'(JOB_DEPTH))
    else $error("job queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> job_level != '0)
    else $error("divider took a job from an empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(empty) |-> $past(result_load))
    else $error("result appeared without a finished right window");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_load |-> (empty || pop))
    else $error("result overwritten before it was taken");

endmodule

>>> bench/tb_eye_window_dark_centroid.sv
module tb_eye_window_dark_centroid;
    import ewdc_pkg::*;

    localparam int WINDOW_SIDE      = 256;
    localparam int DRAIN_CYCLES     = 200;
    localparam int CYCLE_LIMIT      = 2_000_000;
    localparam int RANDOM_PHASES    = 8;
    localparam int PIXELS_PER_PHASE = 120;
    localparam int SATURATING_RUN   = 64;
    localparam int REPORT_LIMIT     = 10;
    localparam logic [PIX_W-1:0] PIX_TOP = '1;
    localparam logic [ORG_W-1:0] ORG_TOP = '1;

    typedef struct packed {
        logic             eye;
        logic [PIX_W-1:0] col;
        logic [PIX_W-1:0] row;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic             last;
    } pixel_t;

    typedef struct {
        logic [CTR_W-1:0]         left_x;
        logic [CTR_W-1:0]         left_y;
        logic [CTR_W-1:0]         right_x;
        logic [CTR_W-1:0]         right_y;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
    } centers_t;

    class centroid_tracker;
        logic [PIX_W-1:0] threshold;
        logic [ORG_W-1:0] org_lx, org_ly, org_rx, org_ry;
        int unsigned      sum_lc, sum_lr, cnt_l;
        int unsigned      sum_rc, sum_rr, cnt_r;
        logic [PIX_W-1:0] held_lx, held_ly;
        centers_t         expected_centers[$];
        int               failures;

        function new();
            threshold = THRESHOLD_RESET;
            org_lx = '0;
            org_ly = '0;
            org_rx = '0;
            org_ry = '0;
            sum_lc = 0;
            sum_lr = 0;
            cnt_l = 0;
            sum_rc = 0;
            sum_rr = 0;
            cnt_r = 0;
            held_lx = '0;
            held_ly = '0;
            failures = 0;
        endfunction

        function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
            case (idx)
                REG_GRAY_THRESHOLD: threshold = data[PIX_W-1:0];
                REG_LEFT_ORIGIN_X:  org_lx = data[ORG_W-1:0];
                REG_LEFT_ORIGIN_Y:  org_ly = data[ORG_W-1:0];
                REG_RIGHT_ORIGIN_X: org_rx = data[ORG_W-1:0];
                REG_RIGHT_ORIGIN_Y: org_ry = data[ORG_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned sat_add(int unsigned a, int unsigned b, int unsigned top);
            return (a + b > top) ? top : a + b;
        endfunction

        // truncating mean, zero for an empty window, clamped to one pixel width
        function logic [PIX_W-1:0] mean_offset(int unsigned total, int unsigned n);
            int unsigned q;
            if (n == 0)
                return '0;
            q = total / n;
            return (q > OFFSET_MAX) ? OFFSET_MAX : PIX_W'(q);
        endfunction

        function void take_pixel(pixel_t p);
            int unsigned gray;
            logic        kept;
            centers_t    c;
            // Q14 luma weights with rounding
            gray = (32'd1868 * p.blue + 32'd9617 * p.green + 32'd4899 * p.red + 32'd8192) >> 14;
            kept = gray > threshold && p.col < WINDOW_SIDE && p.row < WINDOW_SIDE;
            if (p.eye == EYE_LEFT) begin
                if (kept) begin
                    sum_lc = sat_add(sum_lc, p.col, SUM_MAX);
                    sum_lr = sat_add(sum_lr, p.row, SUM_MAX);
                    cnt_l = sat_add(cnt_l, 1, CNT_MAX);
                end
                if (p.last) begin
                    held_lx = mean_offset(sum_lc, cnt_l);
                    held_ly = mean_offset(sum_lr, cnt_l);
                    sum_lc = 0;
                    sum_lr = 0;
                    cnt_l = 0;
                end
                return;
            end
            if (kept) begin
                sum_rc = sat_add(sum_rc, p.col, SUM_MAX);
                sum_rr = sat_add(sum_rr, p.row, SUM_MAX);
                cnt_r = sat_add(cnt_r, 1, CNT_MAX);
            end
            if (!p.last)
                return;
            c.left_x = CTR_W'(int'(org_lx) + int'(held_lx));
            c.left_y = CTR_W'(int'(org_ly) + int'(held_ly));
            c.right_x = CTR_W'(int'(org_rx) + int'(mean_offset(sum_rc, cnt_r)));
            c.right_y = CTR_W'(int'(org_ry) + int'(mean_offset(sum_rr, cnt_r)));
            c.dx = DIFF_W'(int'(c.right_x) - int'(c.left_x));
            c.dy = DIFF_W'(int'(c.right_y) - int'(c.left_y));
            sum_rc = 0;
            sum_rr = 0;
            cnt_r = 0;
            expected_centers.push_back(c);
        endfunction

        function void flag(string what);
            if (failures < REPORT_LIMIT)
                $display("MISMATCH %s", what);
            failures++;
        endfunction

        function void compare_field(string what, int want, int got);
            if (want != got)
                flag($sformatf("%s: expected %0d, got %0d", what, want, got));
        endfunction

        function void check_centers(centers_t got);
            centers_t want;
            if (expected_centers.size() == 0) begin
                flag("result transaction with no expectation pending");
                return;
            end
            want = expected_centers.pop_front();
            compare_field("left_center_x", want.left_x, got.left_x);
            compare_field("left_center_y", want.left_y, got.left_y);
            compare_field("right_center_x", want.right_x, got.right_x);
            compare_field("right_center_y", want.right_y, got.right_y);
            compare_field("diff_x", int'(want.dx), int'(got.dx));
            compare_field("diff_y", int'(want.dy), int'(got.dy));
        endfunction

        function int pending();
            return expected_centers.size();
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     push = 1'b0;
    logic                     pop = 1'b0;
    logic                     cfg_write = 1'b0;
    logic [CFG_IW-1:0]        cfg_index = '0;
    logic [CFG_DW-1:0]        cfg_data = '0;
    pixel_t                   px = '0;
    logic                     full;
    logic                     empty;
    logic [CTR_W-1:0]         left_center_x, left_center_y;
    logic [CTR_W-1:0]         right_center_x, right_center_y;
    logic signed [DIFF_W-1:0] diff_x, diff_y;

    centroid_tracker tracker;
    int              burst_left = 0;
    bit              steady = 1'b0;
    int              pop_run = 0;
    int              pop_roll;
    int unsigned     cycle_count = 0;

    eye_window_dark_centroid uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .eye_select     (px.eye),
        .pixel_col      (px.col),
        .pixel_row      (px.row),
        .blue           (px.blue),
        .green          (px.green),
        .red            (px.red),
        .window_end     (px.last),
        .empty          (empty),
        .pop            (pop),
        .left_center_x  (left_center_x),
        .left_center_y  (left_center_y),
        .right_center_x (right_center_x),
        .right_center_y (right_center_y),
        .diff_x         (diff_x),
        .diff_y         (diff_y),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("eye_window_dark_centroid test failed");
        $finish;
    end

    // both transactions sampled on the rising edge, before the block updates
    always @(posedge clk)
    begin : monitor
        centers_t seen;
        if (rst_n) begin
            if (push && !full)
                tracker.take_pixel(px);
            if (pop && !empty) begin
                seen.left_x = left_center_x;
                seen.left_y = left_center_y;
                seen.right_x = right_center_x;
                seen.right_y = right_center_y;
                seen.dx = diff_x;
                seen.dy = diff_y;
                tracker.check_centers(seen);
            end
        end
    end

    // receiver: mostly ready, short stalls, now and then a long one
    always @(negedge clk)
    begin
        if (pop_run == 0) begin
            pop_roll = $urandom_range(0, 9);
            if (pop_roll < 6) begin
                pop <= 1'b1;
                pop_run <= $urandom_range(1, 40);
            end else begin
                pop <= 1'b0;
                pop_run <= $urandom_range(1, (pop_roll == 9) ? 60 : 6);
            end
        end else begin
            pop_run <= pop_run - 1;
        end
    end

    task automatic send_pixel(pixel_t p);
        int gap;
        if (!steady && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 4);
            repeat (gap) begin
                @(negedge clk);
                push <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        push <= 1'b1;
        px <= p;
        do @(posedge clk); while (full);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        // a left window end leaves the divider busy with no result to show for it
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        tracker.write_reg(idx, data);
    endtask

    task automatic configure(int thr, int lx, int ly, int rx, int ry);
        drain();
        write_reg(REG_GRAY_THRESHOLD, CFG_DW'(thr));
        write_reg(REG_LEFT_ORIGIN_X, CFG_DW'(lx));
        write_reg(REG_LEFT_ORIGIN_Y, CFG_DW'(ly));
        write_reg(REG_RIGHT_ORIGIN_X, CFG_DW'(rx));
        write_reg(REG_RIGHT_ORIGIN_Y, CFG_DW'(ry));
        // unmapped index must leave everything alone
        write_reg(CFG_IW'($urandom_range(int'(REG_RIGHT_ORIGIN_Y) + 1, (1 << CFG_IW) - 1)),
                  CFG_DW'($urandom));
    endtask

    function automatic pixel_t make_pixel(logic eye, int col, int row, int b, int g, int r,
                                          logic last);
        pixel_t p;
        p.eye = eye;
        p.col = PIX_W'(col);
        p.row = PIX_W'(row);
        p.blue = PIX_W'(b);
        p.green = PIX_W'(g);
        p.red = PIX_W'(r);
        p.last = last;
        return p;
    endfunction

    function automatic logic [PIX_W-1:0] pick_extreme();
        return $urandom_range(0, 1) ? PIX_TOP : '0;
    endfunction

    function automatic pixel_t random_pixel(logic eye, logic last);
        pixel_t p;
        int     lvl;
        int     mode;
        p.eye = eye;
        p.last = last;
        p.col = ($urandom_range(0, 6) == 0) ? pick_extreme() : PIX_W'($urandom);
        p.row = ($urandom_range(0, 6) == 0) ? pick_extreme() : PIX_W'($urandom);
        mode = $urandom_range(0, 9);
        if (mode < 4) begin
            p.blue = PIX_W'($urandom);
            p.green = PIX_W'($urandom);
            p.red = PIX_W'($urandom);
        end else if (mode < 7) begin
            // equal channels give gray equal to the level: straddle the threshold
            lvl = int'(tracker.threshold) + $urandom_range(0, 4) - 2;
            lvl = (lvl < 0) ? 0 : (lvl > 255) ? 255 : lvl;
            p.blue = PIX_W'(lvl);
            p.green = PIX_W'(lvl);
            p.red = PIX_W'(lvl);
        end else if (mode < 9) begin
            p.blue = pick_extreme();
            p.green = pick_extreme();
            p.red = pick_extreme();
        end else begin
            p.blue = PIX_TOP;
            p.green = PIX_TOP;
            p.red = PIX_TOP;
        end
        return p;
    endfunction

    task automatic send_window(logic eye, int n, logic ends);
        for (int i = 0; i < n; i++)
            send_pixel(random_pixel(eye, ends && i == n - 1));
    endtask

    task automatic random_traffic(int n_pixels);
        int sent;
        int kind;
        int nl;
        int nr;
        sent = 0;
        while (sent < n_pixels) begin
            kind = $urandom_range(0, 9);
            nl = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(1, 16);
            nr = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(1, 16);
            if (kind < 7) begin
                send_window(EYE_LEFT, nl, 1'b1);
                send_window(EYE_RIGHT, nr, 1'b1);
                sent += nl + nr;
            end else if (kind == 7) begin
                // left window end missing: right end uses the held offsets
                send_window(EYE_LEFT, nl, 1'b0);
                send_window(EYE_RIGHT, nr, 1'b1);
                sent += nl + nr;
            end else if (kind == 8) begin
                for (int i = 0; i < nl; i++)
                    send_pixel(random_pixel(1'($urandom_range(0, 1)),
                                            $urandom_range(0, 3) == 0));
                sent += nl;
            end else begin
                send_window(EYE_RIGHT, nr, 1'b1);
                sent += nr;
            end
        end
    endtask

    initial
    begin
        tracker = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // right window straight after reset: held left offsets still zero,
        // gray one above the reset threshold is kept
        send_pixel(make_pixel(EYE_RIGHT, 5, 6, 31, 31, 31, 1'b1));
        // left window at both corners, gray equal to threshold dropped
        send_pixel(make_pixel(EYE_LEFT, 0, 0, 255, 255, 255, 1'b0));
        send_pixel(make_pixel(EYE_LEFT, 255, 255, 255, 255, 255, 1'b0));
        send_pixel(make_pixel(EYE_LEFT, 100, 100, 30, 30, 30, 1'b0));
        send_pixel(make_pixel(EYE_LEFT, 7, 9, 0, 0, 0, 1'b1));
        send_pixel(make_pixel(EYE_RIGHT, 255, 255, 255, 255, 255, 1'b0));
        send_pixel(make_pixel(EYE_RIGHT, 255, 0, 255, 0, 0, 1'b0));
        send_pixel(make_pixel(EYE_RIGHT, 0, 255, 0, 0, 255, 1'b1));
        // both windows empty
        send_pixel(make_pixel(EYE_LEFT, 40, 40, 0, 0, 0, 1'b1));
        send_pixel(make_pixel(EYE_RIGHT, 41, 41, 0, 0, 0, 1'b1));
        // left end missing, then the left sums carry into the next left window
        send_pixel(make_pixel(EYE_LEFT, 200, 10, 255, 255, 255, 1'b0));
        send_pixel(make_pixel(EYE_RIGHT, 3, 3, 255, 255, 255, 1'b1));
        send_pixel(make_pixel(EYE_LEFT, 100, 50, 255, 255, 255, 1'b1));
        send_pixel(make_pixel(EYE_RIGHT, 1, 2, 0, 255, 0, 1'b1));
        // window end on a lone pixel, eye switching mid-window
        send_pixel(make_pixel(EYE_LEFT, 128, 64, 200, 200, 200, 1'b1));
        send_pixel(make_pixel(EYE_RIGHT, 17, 200, 90, 90, 90, 1'b0));
        send_pixel(make_pixel(EYE_LEFT, 64, 128, 90, 90, 90, 1'b1));
        send_pixel(make_pixel(EYE_RIGHT, 255, 255, 255, 255, 255, 1'b1));

        // back-to-back full-scale windows at the far corner, right origins near the top
        configure(0, 5, 6, 2040, int'(ORG_TOP));
        steady = 1'b1;
        for (int i = 0; i < SATURATING_RUN; i++)
            send_pixel(make_pixel(EYE_LEFT, 255, 255, 255, 255, 255, i == SATURATING_RUN - 1));
        for (int i = 0; i < SATURATING_RUN; i++)
            send_pixel(make_pixel(EYE_RIGHT, 255, 254, 255, 255, 255,
                                  i == SATURATING_RUN - 1));
        steady = 1'b0;

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: configure(0, int'(ORG_TOP), 0, 0, int'(ORG_TOP));
                1: configure(255, 0, int'(ORG_TOP), int'(ORG_TOP), 0);
                2: configure(30, int'(ORG_TOP), int'(ORG_TOP), int'(ORG_TOP), int'(ORG_TOP));
                default: configure($urandom_range(0, 255), $urandom_range(0, 2047),
                                   $urandom_range(0, 2047), $urandom_range(0, 2047),
                                   $urandom_range(0, 2047));
            endcase
            random_traffic(PIXELS_PER_PHASE);
        end

        drain();
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("eye_window_dark_centroid test passed");
        else
            $display("eye_window_dark_centroid test failed");
        $finish;
    end

endmodule
